@@ rtl/qtt_pkg.sv @@
`timescale 1ns / 1ps

package qtt_pkg;

    localparam int POSITION_BITS = 24;
    localparam int LENGTH_BITS   = 16;
    localparam int CLS_W         = 5;
    localparam int KW_COUNT      = 13;

    typedef logic [CLS_W-1:0]         t_cls;
    typedef logic [POSITION_BITS-1:0] t_pos;
    typedef logic [LENGTH_BITS-1:0]   t_len;
    // First byte of a run sits in the top byte, unused bytes are zero.
    typedef logic [63:0]              t_prefix;

    localparam t_cls CLS_DOT    = 5'd13;
    localparam t_cls CLS_SEMI   = 5'd14;
    localparam t_cls CLS_LPAREN = 5'd15;
    localparam t_cls CLS_RPAREN = 5'd16;
    localparam t_cls CLS_LT     = 5'd17;
    localparam t_cls CLS_GT     = 5'd18;
    localparam t_cls CLS_LBRACE = 5'd19;
    localparam t_cls CLS_RBRACE = 5'd20;
    localparam t_cls CLS_COMMA  = 5'd21;
    localparam t_cls CLS_REGEX  = 5'd22;
    localparam t_cls CLS_NUMBER = 5'd23;
    localparam t_cls CLS_IDENT  = 5'd24;
    localparam t_cls CLS_UNTERM = 5'd25;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;

    localparam t_prefix KW_TEXT [KW_COUNT] = '{
        {"create", 16'h0}, {"view", 32'h0}, {"as", 48'h0}, {"output", 16'h0},
        {"select", 16'h0}, {"from", 32'h0}, {"extract", 8'h0}, {"regex", 24'h0},
        {"on", 48'h0}, {"return", 16'h0}, {"group", 24'h0}, {"Token", 24'h0},
        {"pattern", 8'h0}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd4, 4'd2, 4'd6, 4'd6, 4'd4, 4'd7, 4'd5, 4'd2, 4'd6, 4'd5, 4'd5, 4'd7
    };

    typedef struct packed {
        t_cls cls;
        t_pos start;
        t_len len;
        t_pos line;
        logic last;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_emit;

    function automatic logic is_digit(logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alnum(logic [7:0] b);
        return is_digit(b) || ((b >= 8'h61) && (b <= 8'h7A)) ||
               ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic t_cls punct_class(logic [7:0] b);
        t_cls cls;
        case (b)
            CH_DOT:    cls = CLS_DOT;
            CH_SEMI:   cls = CLS_SEMI;
            CH_LPAREN: cls = CLS_LPAREN;
            CH_RPAREN: cls = CLS_RPAREN;
            CH_LT:     cls = CLS_LT;
            CH_GT:     cls = CLS_GT;
            CH_LBRACE: cls = CLS_LBRACE;
            CH_RBRACE: cls = CLS_RBRACE;
            CH_COMMA:  cls = CLS_COMMA;
            default:   cls = CLS_IDENT;
        endcase
        return cls;
    endfunction

    // A run longer than eight bytes never matches, since every keyword is shorter.
    function automatic t_cls run_class(t_prefix prefix, t_len len, logic digits);
        t_cls cls;
        cls = digits ? CLS_NUMBER : CLS_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if ((len == LENGTH_BITS'(KW_LEN[k])) && (prefix == KW_TEXT[k])) begin
                cls = t_cls'(k);
            end
        end
        return cls;
    endfunction

    function automatic t_token mk_token(t_cls cls, t_pos start, t_len len, t_pos line);
        t_token tok;
        tok.cls   = cls;
        tok.start = start;
        tok.len   = len;
        tok.line  = line;
        tok.last  = 1'b0;
        return tok;
    endfunction

endpackage

@@ rtl/query_text_tokenizer.sv @@
`timescale 1ns / 1ps
// Channel    Direction  tdata                                 tuser           tlast
// s_axis     in         [7:0] char_byte                       -               end_of_text
// m_axis     out        [23:0] start_offset, [39:24] length,  [4:0] class     last_of_byte
//                       [63:40] line_number
//
// A byte is registered, lexed combinationally and its tokens are loaded into the output stage.
// One byte per cycle is sustained while each byte gives at most one token and m_axis is ready;
// a byte that closes a run and makes its own token loads both tokens into the output stage.
// Synchronous active-low reset clears position to 0, line to 1 and all open runs.
// Backpressure on m_axis stalls the lexer at a byte that gives a token; it waits in the input register.

module query_text_tokenizer
    import qtt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [23:0] start_offset, [39:24] token_length,
                                        // [63:40] line_number
    output logic [4:0]  m_axis_tuser,   // [4:0] token_class
    output logic        m_axis_tlast
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_eot;
    logic       take;
    logic       can_push;
    t_emit      emit;
    t_token     tok;

    // A byte that makes no token never waits for the output stage.
    assign take = in_valid && ((emit.count == 2'd0) || can_push);

    qtt_in_reg u_in_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tlast  (s_axis_tlast),
        .i_take   (take),
        .o_valid  (in_valid),
        .o_byte   (in_byte),
        .o_eot    (in_eot)
    );

    qtt_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (take),
        .i_byte  (in_byte),
        .i_eot   (in_eot),
        .o_emit  (emit)
    );

    qtt_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (take && (emit.count != 2'd0)),
        .i_emit     (emit),
        .o_can_push (can_push),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tok      (tok)
    );

    assign m_axis_tdata = {tok.line, tok.len, tok.start};
    assign m_axis_tuser = tok.cls;
    assign m_axis_tlast = tok.last;

endmodule

@@ rtl/qtt_in_reg.sv @@
`timescale 1ns / 1ps

module qtt_in_reg
    import qtt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tvalid,
    output logic       o_tready,
    input  logic [7:0] i_tdata,
    input  logic       i_tlast,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_eot
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_eot;

    // The held byte may be replaced in the same cycle that the lexer takes it.
    assign o_tready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tready) begin
            r_valid <= i_tvalid;
        end
        if (o_tready && i_tvalid) begin
            r_byte <= i_tdata;
            r_eot  <= i_tlast;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_eot   = r_eot;

endmodule

@@ rtl/qtt_lexer.sv @@
`timescale 1ns / 1ps

module qtt_lexer
    import qtt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [7:0] i_byte,
    input  logic       i_eot,
    output t_emit      o_emit
);

    t_pos    r_pos, n_pos;
    t_pos    r_start, n_start;
    t_len    r_len, n_len;
    t_pos    r_line, n_line;
    t_prefix r_prefix, n_prefix;
    logic    r_digits, n_digits;
    logic    r_run, n_run;
    logic    r_regex, n_regex;

    t_pos    pos_next;
    t_len    len_inc;
    t_len    len_base;
    t_len    alnum_len;
    t_prefix alnum_prefix;
    logic    alnum_digits;
    logic    have_a, have_b;
    t_token  tok_a, tok_b;

    assign pos_next = r_pos + 1'b1;
    assign len_inc  = (r_len == '1) ? r_len : r_len + 1'b1;

    // A letter or digit either extends the open run or starts a new one.
    always_comb begin
        len_base     = r_run ? r_len : '0;
        alnum_prefix = r_run ? r_prefix : '0;
        alnum_digits = (r_run ? r_digits : 1'b1) & is_digit(i_byte);
        alnum_len    = (len_base == '1) ? len_base : len_base + 1'b1;
        if (len_base < LENGTH_BITS'(8)) begin
            alnum_prefix[{~len_base[2:0], 3'b000} +: 8] = i_byte;
        end
    end

    always_comb begin
        n_pos    = r_pos;
        n_start  = r_start;
        n_len    = r_len;
        n_line   = r_line;
        n_prefix = r_prefix;
        n_digits = r_digits;
        n_run    = r_run;
        n_regex  = r_regex;
        have_a   = 1'b0;
        have_b   = 1'b0;
        tok_a    = '0;
        tok_b    = '0;

        if (r_regex) begin
            if (i_byte == CH_SLASH) begin
                have_b  = 1'b1;
                tok_b   = mk_token(CLS_REGEX, r_start, r_len, r_line);
                n_regex = 1'b0;
            end else begin
                n_len = len_inc;
                if (i_eot) begin
                    have_b  = 1'b1;
                    tok_b   = mk_token(CLS_UNTERM, r_start, len_inc, r_line);
                    n_regex = 1'b0;
                end
            end
        end else if (is_alnum(i_byte)) begin
            n_start  = r_run ? r_start : r_pos;
            n_len    = alnum_len;
            n_prefix = alnum_prefix;
            n_digits = alnum_digits;
            n_run    = 1'b1;
            if (i_eot) begin
                have_b = 1'b1;
                tok_b  = mk_token(run_class(alnum_prefix, alnum_len, alnum_digits),
                                  n_start, alnum_len, r_line);
                n_run  = 1'b0;
            end
        end else begin
            // Any other byte closes an open run before its own token.
            if (r_run) begin
                have_a = 1'b1;
                tok_a  = mk_token(run_class(r_prefix, r_len, r_digits),
                                  r_start, r_len, r_line);
                n_run  = 1'b0;
            end
            if (i_byte == CH_SLASH) begin
                n_start = pos_next;
                n_len   = '0;
                n_regex = 1'b1;
                if (i_eot) begin
                    have_b  = 1'b1;
                    tok_b   = mk_token(CLS_UNTERM, pos_next, '0, r_line);
                    n_regex = 1'b0;
                end
            end else if ((i_byte == CH_SPACE) || (i_byte == CH_TAB)) begin
                n_line = r_line;
            end else if (i_byte == CH_NEWLINE) begin
                n_line = (r_line == '1) ? r_line : r_line + 1'b1;
            end else begin
                have_b = 1'b1;
                tok_b  = mk_token(punct_class(i_byte), r_pos, t_len'(1), r_line);
            end
        end

        if (i_eot) begin
            n_pos    = '0;
            n_start  = '0;
            n_len    = '0;
            n_line   = t_pos'(1);
            n_prefix = '0;
            n_digits = 1'b1;
            n_run    = 1'b0;
            n_regex  = 1'b0;
        end else begin
            n_pos = pos_next;
        end
    end

    always_comb begin
        o_emit.count     = {have_a & have_b, have_a ^ have_b};
        o_emit.tok0      = have_a ? tok_a : tok_b;
        o_emit.tok0.last = !(have_a && have_b);
        o_emit.tok1      = tok_b;
        o_emit.tok1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_line   <= t_pos'(1);
            r_prefix <= '0;
            r_digits <= 1'b1;
            r_run    <= 1'b0;
            r_regex  <= 1'b0;
        end else if (i_go) begin
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_len    <= n_len;
            r_line   <= n_line;
            r_prefix <= n_prefix;
            r_digits <= n_digits;
            r_run    <= n_run;
            r_regex  <= n_regex;
        end
    end

`ifndef SYNTHESIS
    a_not_run_and_regex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_run && r_regex))
        else $error("run and regex open together");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line counter reached zero");

    a_eot_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_eot) |=> (r_pos == '0) && !r_run && !r_regex)
        else $error("end of text did not restart the lexer");
`endif

endmodule

@@ rtl/qtt_out_stage.sv @@
`timescale 1ns / 1ps

module qtt_out_stage
    import qtt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_emit  i_emit,
    output logic   o_can_push,
    output logic   o_tvalid,
    input  logic   i_tready,
    output t_token o_tok
);

    logic [1:0] r_cnt;
    logic       r_sel;
    t_token     r_tok0;
    t_token     r_tok1;
    logic       pop;

    assign o_tvalid   = (r_cnt != 2'd0);
    assign pop        = o_tvalid && i_tready;
    assign o_can_push = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign o_tok      = r_sel ? r_tok1 : r_tok0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_sel <= 1'b0;
        end else if (i_push) begin
            r_cnt <= i_emit.count;
            r_sel <= 1'b0;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
            r_sel <= (r_cnt == 2'd2);
        end
        if (i_push) begin
            r_tok0 <= i_emit.tok0;
            r_tok1 <= i_emit.tok1;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result count out of range");

    a_pair_starts_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !r_sel)
        else $error("second result shown before the first");

    a_pair_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !r_tok0.last)
        else $error("first of two results flagged as last");
`endif

endmodule
